>>> rtl/core/sdod_pkg.sv
package sdod_pkg;

    localparam int MAX_DISTINCT = 64;
    localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);
    localparam int KEY_W        = 64;
    localparam int COL_W        = 20;
    localparam int VAR_W        = 8;
    localparam int NC_W         = 10;
    localparam int FUNC_W       = 2;
    localparam int OUT_DATA_W   = 120;

    localparam logic [COL_W-1:0]  COL_MAX = '1;
    localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(MAX_DISTINCT);

    // Operation codes carried in s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic REG_OMIT_MIN = 1'b0;
    localparam logic REG_NUM_CONT = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        logic occ;
        logic lt;
        logic eq;
    } cell_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DROP,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/core/sdod_cell.sv
module sdod_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sdod_pkg::cell_op_t        op,
    input  logic [sdod_pkg::KEY_W-1:0] key,
    input  logic [sdod_pkg::KEY_W-1:0] prev_value,
    input  sdod_pkg::cell_stat_t      prev_stat,
    input  logic [sdod_pkg::KEY_W-1:0] next_value,
    input  logic                      next_occ,
    output logic [sdod_pkg::KEY_W-1:0] value,
    output sdod_pkg::cell_stat_t      stat
);
    import sdod_pkg::*;

    logic [KEY_W-1:0] value_reg;
    logic [KEY_W-1:0] value_next;
    logic             occ_reg;
    logic             occ_next;
    logic             take;

    assign value    = value_reg;
    assign stat.occ = occ_reg;
    assign stat.lt  = occ_reg && (key < value_reg);
    assign stat.eq  = occ_reg && (key == value_reg);

    // An occupied cell takes part when the key sorts below it; the first free
    // cell takes part when its lower neighbor is occupied.
    assign take = occ_reg ? stat.lt : prev_stat.occ;

    always_comb begin
        value_next = value_reg;
        occ_next   = occ_reg;
        case (op)
            CELL_INSERT: begin
                if (take) begin
                    value_next = prev_stat.lt ? prev_value : key;
                end
                occ_next = occ_reg | prev_stat.occ;
            end
            CELL_SHIFT: begin
                value_next = next_value;
                occ_next   = next_occ;
            end
            CELL_CLEAR: begin
                occ_next = 1'b0;
            end
            default: begin
                value_next = value_reg;
                occ_next   = occ_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

>>> rtl/core/sdod_chain.sv
module sdod_chain (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  sdod_pkg::cell_op_t                op,
    input  logic [sdod_pkg::KEY_W-1:0]        key,
    output logic [sdod_pkg::KEY_W-1:0]        head_value,
    output logic                              dup,
    output logic [sdod_pkg::MAX_DISTINCT-1:0] occ_vec
);
    import sdod_pkg::*;

    logic [KEY_W-1:0] cell_value [MAX_DISTINCT];
    logic [KEY_W-1:0] prev_value [MAX_DISTINCT];
    logic [KEY_W-1:0] next_value [MAX_DISTINCT];
    cell_stat_t       cell_stat  [MAX_DISTINCT];
    cell_stat_t       prev_stat  [MAX_DISTINCT];
    logic             next_occ   [MAX_DISTINCT];
    logic [MAX_DISTINCT-1:0] eq_vec;

    genvar i;
    generate
        for (i = 0; i < MAX_DISTINCT; i++) begin : g_cell
            if (i == 0) begin : g_head
                // The slot below the head counts as occupied so that an empty
                // chain fills from the bottom.
                assign prev_value[i] = '0;
                assign prev_stat[i]  = '{occ: 1'b1, lt: 1'b0, eq: 1'b0};
            end else begin : g_body
                assign prev_value[i] = cell_value[i-1];
                assign prev_stat[i]  = cell_stat[i-1];
            end
            if (i == MAX_DISTINCT - 1) begin : g_tail
                assign next_value[i] = '0;
                assign next_occ[i]   = 1'b0;
            end else begin : g_mid
                assign next_value[i] = cell_value[i+1];
                assign next_occ[i]   = cell_stat[i+1].occ;
            end

            sdod_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .op         (op),
                .key        (key),
                .prev_value (prev_value[i]),
                .prev_stat  (prev_stat[i]),
                .next_value (next_value[i]),
                .next_occ   (next_occ[i]),
                .value      (cell_value[i]),
                .stat       (cell_stat[i])
            );

            assign eq_vec[i]  = cell_stat[i].eq;
            assign occ_vec[i] = cell_stat[i].occ;
        end
    endgenerate

    assign head_value = cell_value[0];
    assign dup        = |eq_vec;

endmodule

>>> rtl/core/sorted_distinct_onehot_dictionary.sv
// Insert and restart words produce no result.
// A close word first latches its bookkeeping, passes through ST_DROP to discard
// the smallest value when that option is set, then loads one result per cycle
// while the output register is free, as the cell chain shifts toward the head;
// s_tready is low until the last result is loaded.
// Synchronous active-low reset empties the chain and clears counters, flags and config.
module sorted_distinct_onehot_dictionary (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sdod_pkg::KEY_W-1:0]          s_tdata,   // key
    input  logic [sdod_pkg::FUNC_W-1:0]         s_tuser,   // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // variable_index, column_index, value, group_count, total_columns, overflow
    output logic [sdod_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,   // value_valid
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [sdod_pkg::NC_W-1:0]           cfg_data
);
    import sdod_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic                 omit_min_reg;
    logic [NC_W-1:0]      num_cont_reg;
    logic [COL_W-1:0]     offset_reg;
    logic [VAR_W-1:0]     var_reg;
    logic                 ovf_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     k_reg;
    logic [COL_W:0]       col_reg;
    logic [COL_W-1:0]     total_reg;
    logic [VAR_W-1:0]     vidx_reg;

    logic                 m_valid_reg;
    logic [VAR_W-1:0]     o_var_reg;
    logic [COL_W-1:0]     o_col_reg;
    logic [KEY_W-1:0]     o_value_reg;
    logic                 o_valid_reg;
    logic [CNT_W-1:0]     o_count_reg;
    logic [COL_W-1:0]     o_total_reg;
    logic                 o_ovf_reg;
    logic                 o_last_reg;

    cell_op_t             cell_op;
    logic [KEY_W-1:0]     head_value;
    logic                 dup;
    logic [MAX_DISTINCT-1:0] occ_vec;

    logic                 in_acc;
    logic                 full;
    logic                 first;
    logic [CNT_W-1:0]     n_close;
    logic [COL_W:0]       off_sum;
    logic [COL_W-1:0]     new_off;
    logic [COL_W:0]       tot_sum;
    logic [COL_W:0]       base;
    logic                 out_free;
    logic                 load_out;
    logic [CNT_W-1:0]     k_inc;
    logic                 is_last;
    logic                 ins_ok;

    sdod_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (cell_op),
        .key        (s_tdata),
        .head_value (head_value),
        .dup        (dup),
        .occ_vec    (occ_vec)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign full     = (fill_reg == FILL_FULL);
    assign ins_ok   = !dup && !full;
    assign first    = omit_min_reg && (fill_reg != '0);
    assign n_close  = fill_reg - CNT_W'(first);
    assign off_sum  = (COL_W+1)'(offset_reg) + (COL_W+1)'(n_close);
    assign new_off  = off_sum[COL_W] ? COL_MAX : off_sum[COL_W-1:0];
    assign tot_sum  = (COL_W+1)'(1) + (COL_W+1)'(num_cont_reg) + (COL_W+1)'(new_off);
    assign base     = (COL_W+1)'(1) + (COL_W+1)'(num_cont_reg) + (COL_W+1)'(offset_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign k_inc    = k_reg + CNT_W'(1);
    assign is_last  = (n_reg == '0) || (k_inc == n_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tuser == FUNC_CLOSE) begin
                    state_next = first ? ST_DROP : ST_EMIT;
                end
            end
            ST_DROP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && is_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cell_op  = CELL_HOLD;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tuser == FUNC_INSERT && ins_ok) begin
                    cell_op = CELL_INSERT;
                end else if (in_acc && s_tuser == FUNC_RESTART) begin
                    cell_op = CELL_CLEAR;
                end
            end
            ST_DROP: begin
                cell_op = CELL_SHIFT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (n_reg != '0) begin
                        cell_op = CELL_SHIFT;
                    end
                end
            end
            default: begin
                cell_op  = CELL_HOLD;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            omit_min_reg   <= 1'b0;
            num_cont_reg   <= '0;
            offset_reg     <= '0;
            var_reg        <= '0;
            ovf_reg        <= 1'b0;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_OMIT_MIN: omit_min_reg <= cfg_data[0];
                    REG_NUM_CONT: num_cont_reg <= cfg_data;
                    default:      num_cont_reg <= num_cont_reg;
                endcase
            end
            if (in_acc) begin
                case (s_tuser)
                    FUNC_INSERT: begin
                        if (ins_ok) begin
                            fill_reg <= fill_reg + CNT_W'(1);
                        end else if (!dup) begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    FUNC_CLOSE: begin
                        offset_reg <= new_off;
                        var_reg    <= var_reg + VAR_W'(1);
                        fill_reg   <= '0;
                    end
                    FUNC_RESTART: begin
                        offset_reg <= '0;
                        var_reg    <= '0;
                        ovf_reg    <= 1'b0;
                        fill_reg   <= '0;
                    end
                    default: begin
                        fill_reg <= fill_reg;
                    end
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Per-close bookkeeping and the output word.
    always_ff @(posedge aclk) begin
        if (in_acc && s_tuser == FUNC_CLOSE) begin
            n_reg     <= n_close;
            k_reg     <= '0;
            col_reg   <= base;
            total_reg <= tot_sum[COL_W] ? COL_MAX : tot_sum[COL_W-1:0];
            vidx_reg  <= var_reg;
        end else if (load_out) begin
            k_reg   <= k_inc;
            col_reg <= col_reg + (COL_W+1)'(1);
        end
        if (load_out) begin
            o_var_reg   <= vidx_reg;
            o_total_reg <= total_reg;
            o_ovf_reg   <= ovf_reg;
            o_last_reg  <= is_last;
            if (n_reg == '0) begin
                o_col_reg   <= '0;
                o_value_reg <= '0;
                o_valid_reg <= 1'b0;
                o_count_reg <= '0;
            end else begin
                o_col_reg   <= col_reg[COL_W] ? COL_MAX : col_reg[COL_W-1:0];
                o_value_reg <= head_value;
                o_valid_reg <= 1'b1;
                o_count_reg <= n_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {o_ovf_reg, o_total_reg, o_count_reg, o_value_reg, o_col_reg, o_var_reg};
    assign m_tuser  = o_valid_reg;
    assign m_tlast  = o_last_reg;

`ifndef SYNTHESIS
    // Occupied cells always form a contiguous run from the head.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_vec & (occ_vec + MAX_DISTINCT'(1))) == '0)
        else $error("cell occupancy is not contiguous");

    // A new distinct key arriving at a full store raises the sticky flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && s_tuser == FUNC_INSERT && full && !dup |=> ovf_reg)
        else $error("overflow not flagged on dropped key");

    // The empty-group word is always the only word of its close.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty-group word without last");

    // While idle, the chain holds exactly as many occupied cells as the fill counter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> $countones(occ_vec) == int'(fill_reg))
        else $error("fill counter disagrees with cell occupancy");
`endif

endmodule

>>> tb/tb_sorted_distinct_onehot_dictionary.sv
`timescale 1ns / 1ps

module tb_sorted_distinct_onehot_dictionary;
    import sdod_pkg::*;

    localparam int          HALF_PERIOD = 4;
    localparam int          STALL_LIMIT = 4000;
    localparam int          VAR_WRAP    = 256;
    localparam int          PHASE_WORDS = 75;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [VAR_W-1:0] var_idx;
        logic [COL_W-1:0] col;
        logic [KEY_W-1:0] value;
        logic             valid;
        logic [6:0]       count;
        logic [COL_W-1:0] total;
        logic             ovf;
        logic             last;
    } onehot_col_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
        logic              fixed;
        onehot_col_t       want;
    } dir_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [NC_W-1:0]       cfg_data  = '0;

    // Predictor state.
    logic [KEY_W-1:0] dict_store [MAX_DISTINCT];
    int unsigned      dict_fill;
    logic [COL_W-1:0] col_offset;
    int unsigned      var_count;
    logic             ovf_flag;
    logic             cfg_omit_min;
    logic [NC_W-1:0]  cfg_num_cont;

    onehot_col_t expected_cols [$];
    dir_word_t   dir_tab [$];
    int          mismatch_cnt = 0;
    int          idle_cycles  = 0;
    int          m_stall      = 0;
    bit          quiet        = 1'b0;

    int               dir_split;
    int               phase;
    int               words;
    int               n_keys;
    bit               big;
    logic             ph_drop;
    logic [NC_W-1:0]  ph_nc;
    logic [KEY_W-1:0] key_pool [8];

    sorted_distinct_onehot_dictionary i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [COL_W-1:0] sat_col(input longint unsigned v);
        return (v > COL_MAX) ? COL_MAX : v[COL_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return key_pool[$urandom_range(0, 7)];
        end else if (r == 4) begin
            return '0;
        end else if (r == 5) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    // Sorted distinct insertion, emission of the store on a close word, and a reset of the predictor on a restart word.
    function automatic void predict_word(input logic [FUNC_W-1:0] func,
                                         input logic [KEY_W-1:0] key,
                                         input logic fixed,
                                         input onehot_col_t want);
        logic [KEY_W-1:0] carry;
        logic [KEY_W-1:0] tmp;
        int unsigned      first;
        int unsigned      n;
        longint unsigned  base;
        logic [COL_W-1:0] new_off;
        logic [COL_W-1:0] total;
        onehot_col_t      c;
        case (func)
            FUNC_INSERT: begin
                for (int i = 0; i < dict_fill; i++) begin
                    if (dict_store[i] == key) return;
                end
                if (dict_fill >= MAX_DISTINCT) begin
                    ovf_flag = 1'b1;
                    return;
                end
                carry = key;
                for (int i = 0; i < dict_fill; i++) begin
                    if (carry < dict_store[i]) begin
                        tmp           = dict_store[i];
                        dict_store[i] = carry;
                        carry         = tmp;
                    end
                end
                dict_store[dict_fill] = carry;
                dict_fill++;
            end
            FUNC_CLOSE: begin
                first   = (cfg_omit_min && dict_fill > 0) ? 1 : 0;
                n       = dict_fill - first;
                base    = 1 + longint'(cfg_num_cont) + longint'(col_offset);
                new_off = sat_col(longint'(col_offset) + n);
                total   = sat_col(1 + longint'(cfg_num_cont) + longint'(new_off));
                c.var_idx = var_count[VAR_W-1:0];
                c.total   = total;
                c.ovf     = ovf_flag;
                if (fixed) begin
                    expected_cols.push_back(want);
                end else if (n == 0) begin
                    c.col   = '0;
                    c.value = '0;
                    c.valid = 1'b0;
                    c.count = '0;
                    c.last  = 1'b1;
                    expected_cols.push_back(c);
                end else begin
                    for (int unsigned k = 0; k < n; k++) begin
                        c.col   = sat_col(base + k);
                        c.value = dict_store[first + k];
                        c.valid = 1'b1;
                        c.count = n[6:0];
                        c.last  = (k + 1 == n);
                        expected_cols.push_back(c);
                    end
                end
                col_offset = new_off;
                var_count  = (var_count + 1) % VAR_WRAP;
                dict_fill  = 0;
            end
            FUNC_RESTART: begin
                col_offset = '0;
                var_count  = 0;
                ovf_flag   = 1'b0;
                dict_fill  = 0;
            end
            default: ;
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays high when the next word
    // follows without a gap.
    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                             input logic fixed = 1'b0, input onehot_col_t want = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= func;
        s_tdata  <= key;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_word(func, key, fixed, want);
        @(negedge aclk);
    endtask

    // Registers change only once every expected word has come out and the
    // block has had time to settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_cols.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_config(input logic omit, input logic [NC_W-1:0] nc);
        cfg_we    <= 1'b1;
        cfg_index <= REG_OMIT_MIN;
        cfg_data  <= NC_W'(omit);
        @(negedge aclk);
        cfg_omit_min = omit;
        cfg_index <= REG_NUM_CONT;
        cfg_data  <= nc;
        @(negedge aclk);
        cfg_num_cont = nc;
        cfg_we <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (m_stall > 0) begin
            m_tready <= 1'b0;
            m_stall  <= m_stall - 1;
        end else begin
            m_tready <= 1'b1;
            m_stall  <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        onehot_col_t got;
        onehot_col_t exp_col;
        if (aresetn && m_tvalid && m_tready) begin
            got.var_idx = m_tdata[7:0];
            got.col     = m_tdata[27:8];
            got.value   = m_tdata[91:28];
            got.count   = m_tdata[98:92];
            got.total   = m_tdata[118:99];
            got.ovf     = m_tdata[119];
            got.valid   = m_tuser;
            got.last    = m_tlast;
            if (expected_cols.size() == 0) begin
                if (mismatch_cnt < 10) begin
                    $display("unexpected word: var=%0d col=%0d value=%h valid=%b",
                             got.var_idx, got.col, got.value, got.valid);
                end
                mismatch_cnt++;
            end else begin
                exp_col = expected_cols.pop_front();
                if (got.var_idx != exp_col.var_idx || got.col != exp_col.col ||
                    got.value != exp_col.value || got.valid != exp_col.valid ||
                    got.count != exp_col.count || got.total != exp_col.total ||
                    got.ovf != exp_col.ovf || got.last != exp_col.last) begin
                    if (mismatch_cnt < 10) begin
                        $write("mismatch exp: var=%0d col=%0d value=%h valid=%b ",
                               exp_col.var_idx, exp_col.col, exp_col.value,
                               exp_col.valid);
                        $display("cnt=%0d tot=%0d ovf=%b last=%b",
                                 exp_col.count, exp_col.total, exp_col.ovf,
                                 exp_col.last);
                        $write("         got: var=%0d col=%0d value=%h valid=%b ",
                               got.var_idx, got.col, got.value, got.valid);
                        $display("cnt=%0d tot=%0d ovf=%b last=%b",
                                 got.count, got.total, got.ovf, got.last);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        dict_fill      = 0;
        col_offset     = '0;
        var_count      = 0;
        ovf_flag       = 1'b0;
        cfg_omit_min   = 1'b0;
        cfg_num_cont   = '0;

        // Empty and single-value groups have results that are plain to see, so those
        // rows carry them directly.
        dir_tab.push_back('{FUNC_CLOSE, 64'd0, 1'b1,
                            '{8'd0, 20'd0, 64'd0, 1'b0, 7'd0, 20'd1, 1'b0, 1'b1}});
        dir_tab.push_back('{FUNC_INSERT, 64'd0, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, '1, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'd5, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'd5, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'd3, 1'b0, '0});
        dir_tab.push_back('{FUNC_UNUSED, 64'hAAAA_5555_AAAA_5555, 1'b0, '0});
        dir_tab.push_back('{FUNC_CLOSE, 64'd0, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'h8000_0000_0000_0000, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0});
        dir_tab.push_back('{FUNC_CLOSE, 64'd0, 1'b0, '0});
        dir_tab.push_back('{FUNC_RESTART, 64'h0123_4567_89AB_CDEF, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'd42, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'd42, 1'b0, '0});
        dir_tab.push_back('{FUNC_CLOSE, 64'd0, 1'b1,
                            '{8'd0, 20'd1, 64'd42, 1'b1, 7'd1, 20'd2, 1'b0, 1'b1}});
        dir_tab.push_back('{FUNC_CLOSE, 64'd0, 1'b1,
                            '{8'd1, 20'd0, 64'd0, 1'b0, 7'd0, 20'd2, 1'b0, 1'b1}});
        dir_split = dir_tab.size();
        // From here on the smallest value is omitted and num_continuous is at
        // its maximum.
        dir_tab.push_back('{FUNC_INSERT, 64'd9, 1'b0, '0});
        dir_tab.push_back('{FUNC_CLOSE, 64'd0, 1'b1,
                            '{8'd2, 20'd0, 64'd0, 1'b0, 7'd0, 20'd1025, 1'b0, 1'b1}});
        dir_tab.push_back('{FUNC_INSERT, 64'd1, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'd2, 1'b0, '0});
        dir_tab.push_back('{FUNC_INSERT, 64'd0, 1'b0, '0});
        dir_tab.push_back('{FUNC_CLOSE, 64'd0, 1'b0, '0});
        dir_tab.push_back('{FUNC_RESTART, '1, 1'b0, '0});
        dir_tab.push_back('{FUNC_CLOSE, 64'd0, 1'b1,
                            '{8'd0, 20'd0, 64'd0, 1'b0, 7'd0, 20'd1024, 1'b0, 1'b1}});

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_config(1'b0, 10'd0);

        for (int i = 0; i < dir_tab.size(); i++) begin
            if (i == dir_split) begin
                wait_idle();
                set_config(1'b1, 10'd1023);
            end
            send_word(dir_tab[i].func, dir_tab[i].key, dir_tab[i].fixed, dir_tab[i].want);
        end

        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            ph_drop = (phase == 1 || phase == 2);
            ph_nc   = (phase == 0) ? 10'd1023 : (phase == 1) ? 10'd0
                                              : 10'($urandom_range(0, 1023));
            set_config(ph_drop, ph_nc);
            for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
            words = 0;
            while (words < PHASE_WORDS) begin
                quiet  = ($urandom_range(0, 4) == 0);
                // The first group of phase 0 is big, so it can overfill the store and show the sticky flag.
                big    = (phase == 0 && words == 0) || ($urandom_range(0, 99) < 12);
                n_keys = big ? $urandom_range(62, 70) : $urandom_range(0, 10);
                for (int k = 0; k < n_keys; k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_word(FUNC_UNUSED, {$urandom, $urandom});
                    end
                    send_word(FUNC_INSERT, big ? {$urandom, $urandom} : rand_key());
                    words++;
                end
                if ($urandom_range(0, 19) == 0) begin
                    send_word(FUNC_RESTART, {$urandom, $urandom});
                end else begin
                    send_word(FUNC_CLOSE, {$urandom, $urandom});
                end
                words++;
            end
        end

        quiet = 1'b0;
        wait_idle();
        repeat (16) @(posedge aclk);
        if (expected_cols.size() != 0) begin
            $display("%0d expected words never arrived", expected_cols.size());
            mismatch_cnt += expected_cols.size();
        end
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
